FILE: hdl/ccs_pkg.sv
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared types and character constants for the C comment stripper.
// ----------------------------------------------------------------------------
`default_nettype none

package ccs_pkg;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_SLASH  = 3'd1,
        MODE_LINE   = 3'd2,
        MODE_BLOCK  = 3'd3,
        MODE_STAR   = 3'd4
    } scan_mode_t;

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_end;
        logic       unterminated;
        logic       last;
    } result_t;

    // Results produced by one accepted item: count of 0, 1 or 2, head first.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } result_pair_t;

endpackage

`default_nettype wire

FILE: hdl/ccs_if.sv
// ----------------------------------------------------------------------------
// ccs_in_if / ccs_out_if
// Valid/ready channels for source text items and filtered result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface ccs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_text;

    modport source (output valid, output in_byte, output end_of_text, input ready);
    modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface ccs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_end;
    logic       unterminated;
    logic       last;

    modport source (output valid, output out_byte, output is_end, output unterminated,
                    output last, input ready);
    modport sink   (input valid, input out_byte, input is_end, input unterminated,
                    input last, output ready);
endinterface

`default_nettype wire

FILE: hdl/ccs_scan.sv
// ----------------------------------------------------------------------------
// ccs_scan
// Scan mode and pending-space state; decodes one item into up to two results.
// ----------------------------------------------------------------------------
`default_nettype none

module ccs_scan (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  take,
    input  wire [7:0]            in_byte,
    input  wire                  end_of_text,
    output ccs_pkg::result_pair_t results
);
    import ccs_pkg::*;

    scan_mode_t mode_reg;
    scan_mode_t mode_next;
    logic       pending_reg;
    logic       pending_next;

    function automatic result_t byte_res(input logic [7:0] b);
        result_t r;
        r.out_byte     = b;
        r.is_end       = 1'b0;
        r.unterminated = 1'b0;
        r.last         = 1'b0;
        return r;
    endfunction

    function automatic result_t end_res(input logic unterm);
        result_t r;
        r.out_byte     = 8'h00;
        r.is_end       = 1'b1;
        r.unterminated = unterm;
        r.last         = 1'b1;
        return r;
    endfunction

    // Next state
    always_comb
    begin
        mode_next    = mode_reg;
        pending_next = pending_reg;
        if (end_of_text)
        begin
            mode_next    = MODE_NORMAL;
            pending_next = 1'b0;
        end
        else
        begin
            unique case (mode_reg)
                MODE_SLASH:
                begin
                    if (in_byte == CH_SLASH)
                        mode_next = MODE_LINE;
                    else if (in_byte == CH_STAR)
                        mode_next = MODE_BLOCK;
                    else
                        mode_next = MODE_NORMAL;
                end
                MODE_LINE:
                begin
                    if (in_byte == CH_NL)
                        mode_next = MODE_NORMAL;
                end
                MODE_BLOCK:
                begin
                    if (in_byte == CH_STAR)
                        mode_next = MODE_STAR;
                end
                MODE_STAR:
                begin
                    if (in_byte == CH_SLASH)
                        mode_next = MODE_NORMAL;
                    else if (in_byte != CH_STAR)
                        mode_next = MODE_BLOCK;
                end
                default:
                begin
                    mode_next = MODE_NORMAL;
                    if (in_byte == CH_SLASH)
                        mode_next = MODE_SLASH;
                    else if (in_byte == CH_BSLASH)
                        pending_next = 1'b1;
                    else if (in_byte != CH_CR && in_byte != CH_TAB)
                        pending_next = 1'b0;
                end
            endcase
        end
    end

    // Outputs
    always_comb
    begin
        results.count  = 2'd0;
        results.first  = byte_res(8'h00);
        results.second = byte_res(8'h00);
        if (end_of_text)
        begin
            if (mode_reg == MODE_SLASH)
            begin
                results.count  = 2'd2;
                results.first  = byte_res(CH_SLASH);
                results.second = end_res(1'b0);
            end
            else
            begin
                results.count = 2'd1;
                results.first = end_res(mode_reg == MODE_BLOCK || mode_reg == MODE_STAR);
            end
        end
        else
        begin
            unique case (mode_reg)
                MODE_SLASH:
                begin
                    if (in_byte != CH_SLASH && in_byte != CH_STAR)
                    begin
                        results.count       = 2'd2;
                        results.first       = byte_res(CH_SLASH);
                        results.second      = byte_res(in_byte);
                        results.second.last = 1'b1;
                    end
                end
                MODE_LINE:
                begin
                    if (in_byte == CH_NL)
                    begin
                        results.count      = 2'd1;
                        results.first      = byte_res(CH_NL);
                        results.first.last = 1'b1;
                    end
                end
                MODE_BLOCK, MODE_STAR:
                begin
                    results.count = 2'd0;
                end
                default:
                begin
                    if (in_byte != CH_SLASH && in_byte != CH_BSLASH)
                    begin
                        results.count = 2'd1;
                        if (in_byte == CH_CR)
                            results.first = byte_res(CH_NL);
                        else if (in_byte == CH_TAB || pending_reg)
                            results.first = byte_res(CH_SPACE);
                        else
                            results.first = byte_res(in_byte);
                        results.first.last = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_NORMAL;
            pending_reg <= 1'b0;
        end
        else if (take)
        begin
            mode_reg    <= mode_next;
            pending_reg <= pending_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/ccs_out_buf.sv
// ----------------------------------------------------------------------------
// ccs_out_buf
// Two-slot result register; loads an item's results and drains one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module ccs_out_buf (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   load,
    input  ccs_pkg::result_pair_t results,
    output logic                  can_load,
    output logic                  out_valid,
    input  wire                   out_ready,
    output ccs_pkg::result_t      head
);
    import ccs_pkg::*;

    logic [1:0] count_reg;
    logic [1:0] count_next;
    result_t    slot0_reg;
    result_t    slot0_next;
    result_t    slot1_reg;
    logic       pop;

    assign out_valid = (count_reg != 2'd0);
    assign head      = slot0_reg;
    assign pop       = out_valid && out_ready;
    // Room exists once the buffer is empty after this cycle's pop.
    assign can_load  = (count_reg == 2'd0) || (count_reg == 2'd1 && out_ready);

    always_comb
    begin
        count_next = count_reg;
        slot0_next = slot0_reg;
        if (load)
        begin
            count_next = results.count;
            slot0_next = results.first;
        end
        else if (pop)
        begin
            count_next = count_reg - 2'd1;
            slot0_next = slot1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        if (load)
            slot1_reg <= results.second;
    end

endmodule

`default_nettype wire

FILE: hdl/c_comment_stripper_top.sv
// ----------------------------------------------------------------------------
// c_comment_stripper_top
// Streaming C comment filter: one source byte or end-of-text item per cycle unless stalled.
// ----------------------------------------------------------------------------
// The first result of an item is offered in the cycle after acceptance.
// Throughput: one item per cycle while each yields at most one result and the
// output is not stalled; an item with two results holds the two-slot output register while they drain.
// Reset: asynchronous, active low; returns to normal mode, no pending space,
// and empties the output register.
`default_nettype none

module c_comment_stripper_top (
    input  wire   clk,
    input  wire   rst_n,
    ccs_in_if.sink    text_in,
    ccs_out_if.source text_out
);
    import ccs_pkg::*;

    result_pair_t results;
    result_t      head;
    logic         can_load;
    logic         take;
    logic         out_valid;

    assign text_in.ready = can_load;
    assign take          = text_in.valid && can_load;

    ccs_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .in_byte     (text_in.in_byte),
        .end_of_text (text_in.end_of_text),
        .results     (results)
    );

    ccs_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take),
        .results   (results),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (text_out.ready),
        .head      (head)
    );

    assign text_out.valid        = out_valid;
    assign text_out.out_byte     = head.out_byte;
    assign text_out.is_end       = head.is_end;
    assign text_out.unterminated = head.unterminated;
    assign text_out.last         = head.last;

endmodule

`default_nettype wire

FILE: hdl/ccs_checker.sv
// ----------------------------------------------------------------------------
// ccs_checker
// Port-level checks on the filtered result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ccs_checker (
    input wire       clk,
    input wire       rst_n,
    input wire       out_valid,
    input wire       out_ready,
    input wire [7:0] out_byte,
    input wire       is_end,
    input wire       unterminated,
    input wire       last
);

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(is_end))
        else $error("stalled result changed");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_end |-> last)
        else $error("completion result not marked last");

    a_byte_not_flagged: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_end |-> !unterminated)
        else $error("byte result carries unterminated flag");

    a_end_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_end |-> out_byte == 8'h00)
        else $error("completion result carries a byte");

endmodule

bind c_comment_stripper_top ccs_checker u_ccs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (text_out.valid),
    .out_ready    (text_out.ready),
    .out_byte     (text_out.out_byte),
    .is_end       (text_out.is_end),
    .unterminated (text_out.unterminated),
    .last         (text_out.last)
);

`default_nettype wire

FILE: tb/ccs_tb_checker.sv
// ----------------------------------------------------------------------------
// ccs_tb_checker
// Watches both channels of the comment stripper. Keeps its own copy of the
// scan mode and the pending space, predicts the filtered bytes and the
// completion result for every accepted item, and compares each accepted
// result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module ccs_tb_checker (
    input  wire  clk,
    input  wire  rst_n,
    ccs_in_if    text_in,
    ccs_out_if   text_out,
    output int   errors,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import ccs_pkg::*;

    scan_mode_t mode;
    logic       space_due;
    result_t    awaited[$];
    int         err_count = 0;

    function automatic result_t byte_result(input logic [7:0] b);
        result_t r;
        r = '0;
        r.out_byte = b;
        return r;
    endfunction

    function automatic bit field_ok(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: mismatch on %s: expected %0h, got %0h", $time, name, want, got);
            return 0;
        end
        return 1;
    endfunction

    task automatic filter_item(input logic [7:0] b, input logic eot);
        result_t res[2];
        int      n;
        n = 0;
        if (eot)
        begin
            // flush a lone slash before the completion result
            if (mode == MODE_SLASH)
            begin
                res[n] = byte_result(CH_SLASH);
                n++;
            end
            res[n] = '0;
            res[n].is_end = 1'b1;
            res[n].unterminated = (mode == MODE_BLOCK || mode == MODE_STAR);
            n++;
            mode = MODE_NORMAL;
            space_due = 1'b0;
        end
        else
        begin
            case (mode)
                MODE_SLASH:
                begin
                    if (b == CH_SLASH)
                        mode = MODE_LINE;
                    else if (b == CH_STAR)
                        mode = MODE_BLOCK;
                    else
                    begin
                        // follower passes unconverted, pending space untouched
                        res[0] = byte_result(CH_SLASH);
                        res[1] = byte_result(b);
                        n = 2;
                        mode = MODE_NORMAL;
                    end
                end
                MODE_LINE:
                begin
                    if (b == CH_NL)
                    begin
                        res[0] = byte_result(CH_NL);
                        n = 1;
                        mode = MODE_NORMAL;
                    end
                end
                MODE_BLOCK:
                begin
                    if (b == CH_STAR)
                        mode = MODE_STAR;
                end
                MODE_STAR:
                begin
                    if (b == CH_SLASH)
                        mode = MODE_NORMAL;
                    else if (b != CH_STAR)
                        mode = MODE_BLOCK;
                end
                default:
                begin
                    if (b == CH_SLASH)
                        mode = MODE_SLASH;
                    else if (b == CH_CR)
                    begin
                        res[0] = byte_result(CH_NL);
                        n = 1;
                    end
                    else if (b == CH_TAB)
                    begin
                        res[0] = byte_result(CH_SPACE);
                        n = 1;
                    end
                    else if (b == CH_BSLASH)
                        space_due = 1'b1;
                    else if (space_due)
                    begin
                        res[0] = byte_result(CH_SPACE);
                        n = 1;
                        space_due = 1'b0;
                    end
                    else
                    begin
                        res[0] = byte_result(b);
                        n = 1;
                    end
                end
            endcase
        end
        if (n > 0)
            res[n - 1].last = 1'b1;
        for (int i = 0; i < n; i++)
            awaited.push_back(res[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t got;
        result_t want;
        bit      ok;
        if (!rst_n)
        begin
            mode = MODE_NORMAL;
            space_due = 1'b0;
            awaited.delete();
        end
        else
        begin
            // compare first: a result never belongs to an item taken this edge
            if (text_out.valid && text_out.ready)
            begin
                got.out_byte     = text_out.out_byte;
                got.is_end       = text_out.is_end;
                got.unterminated = text_out.unterminated;
                got.last         = text_out.last;
                if (awaited.size() == 0)
                begin
                    $display({"%0t: unexpected result: expected none, ",
                              "got byte=%02h end=%0b unterm=%0b last=%0b"},
                             $time, got.out_byte, got.is_end, got.unterminated, got.last);
                    err_count++;
                end
                else
                begin
                    want = awaited.pop_front();
                    ok = field_ok("out_byte", want.out_byte, got.out_byte);
                    ok = field_ok("is_end", want.is_end, got.is_end) && ok;
                    ok = field_ok("unterminated", want.unterminated, got.unterminated) && ok;
                    ok = field_ok("last", want.last, got.last) && ok;
                    if (!ok)
                        err_count++;
                end
            end
            if (text_in.valid && text_in.ready)
                filter_item(text_in.in_byte, text_in.end_of_text);
        end
        errors  <= err_count;
        pending <= awaited.size();
    end

endmodule

`default_nettype wire

FILE: tb/tb_c_comment_stripper_top.sv
// ----------------------------------------------------------------------------
// tb_c_comment_stripper_top
// Drives the comment stripper with a directed run of special cases, then with
// random text that mixes plain bytes with comments, escapes and lone slashes, with random
// gaps on the input side and random stalls on the output side. The checker
// module predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_c_comment_stripper_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ccs_pkg::*;

    localparam int IDLE_LIMIT   = 500;
    localparam int RANDOM_ITEMS = 400;
    localparam int TAIL_CYCLES  = 10;
    localparam int END_MARK     = 256;
    localparam int SIDE_IN      = 0;
    localparam int SIDE_OUT     = 1;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   results_due;
    int   items_sent = 0;
    int   calm_left[2] = '{0, 0};
    int   idle_cycles = 0;

    ccs_in_if  text_in_ch();
    ccs_out_if text_out_ch();

    c_comment_stripper_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .text_in  (text_in_ch),
        .text_out (text_out_ch)
    );

    ccs_tb_checker chk (
        .clk      (clk),
        .rst_n    (rst_n),
        .text_in  (text_in_ch),
        .text_out (text_out_ch),
        .errors   (fail_count),
        .pending  (results_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Gap before the next item; now and then a stretch with no idling at all.
    function automatic int draw_wait(input int side);
        if (calm_left[side] > 0)
        begin
            calm_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm_left[side] = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 10);
    endfunction

    task automatic send_item(input logic [7:0] b, input logic eot);
        int gap;
        gap = draw_wait(SIDE_IN);
        if (gap > 0)
        begin
            text_in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_in_ch.valid       <= 1'b1;
        text_in_ch.in_byte     <= b;
        text_in_ch.end_of_text <= eot;
        do @(posedge clk); while (!text_in_ch.ready);
        items_sent++;
    endtask

    task automatic send_text_end();
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_fragment();
        int         kind;
        int         len;
        logic [7:0] c;
        kind = $urandom_range(0, 19);
        if (kind <= 5)
            send_item(8'($urandom_range(32, 126)), 1'b0);
        else if (kind == 6)
        begin
            case ($urandom_range(0, 3))
                0:       c = CH_TAB;
                1:       c = CH_CR;
                2:       c = CH_NL;
                default: c = CH_BSLASH;
            endcase
            send_item(c, 1'b0);
        end
        else if (kind <= 8)
        begin
            // escape, sometimes repeated, then a follower
            repeat ($urandom_range(1, 2)) send_item(CH_BSLASH, 1'b0);
            if ($urandom_range(0, 3) == 0)
                send_item(CH_TAB, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b0);
        end
        else if (kind <= 10)
        begin
            send_item(CH_SLASH, 1'b0);
            send_item(CH_SLASH, 1'b0);
            len = $urandom_range(0, 6);
            repeat (len)
            begin
                c = ($urandom_range(0, 4) == 0) ? CH_CR : 8'($urandom_range(0, 255));
                if (c == CH_NL)
                    c = CH_STAR;
                send_item(c, 1'b0);
            end
            send_item(CH_NL, 1'b0);
        end
        else if (kind <= 13)
        begin
            send_item(CH_SLASH, 1'b0);
            send_item(CH_STAR, 1'b0);
            len = $urandom_range(0, 6);
            repeat (len)
            begin
                c = ($urandom_range(0, 3) == 0) ? CH_STAR : 8'($urandom_range(0, 255));
                send_item(c, 1'b0);
            end
            repeat ($urandom_range(1, 3)) send_item(CH_STAR, 1'b0);
            send_item(CH_SLASH, 1'b0);
        end
        else if (kind == 14)
        begin
            send_item(CH_SLASH, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b0);
        end
        else if (kind <= 17)
            send_item(8'($urandom_range(0, 255)), 1'b0);
        else if (kind == 18)
            send_text_end();
        else
        begin
            // end of text soon after a slash, often inside a comment or right after the slash
            send_item(CH_SLASH, 1'b0);
            case ($urandom_range(0, 2))
                0: send_item(CH_STAR, 1'b0);
                1: send_item(CH_SLASH, 1'b0);
                default: ;
            endcase
            repeat ($urandom_range(0, 3))
                send_item(($urandom_range(0, 1) == 0) ? CH_STAR : 8'($urandom_range(0, 255)),
                          1'b0);
            send_text_end();
        end
    endtask

    int directed_text[28] = '{
        8'h00, 8'hFF, CH_TAB, CH_CR, CH_BSLASH, CH_BSLASH, CH_SLASH, "x", "q",
        CH_SLASH, CH_STAR, CH_SLASH, CH_STAR, CH_STAR, CH_SLASH,
        CH_SLASH, CH_SLASH, CH_CR, CH_NL,
        CH_SLASH, END_MARK,
        CH_SLASH, CH_SLASH, END_MARK,
        CH_SLASH, CH_STAR, CH_STAR, END_MARK
    };

    initial
    begin
        rst_n = 1'b0;
        text_in_ch.valid       = 1'b0;
        text_in_ch.in_byte     = 8'h00;
        text_in_ch.end_of_text = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_text[i])
        begin
            if (directed_text[i] == END_MARK)
                send_text_end();
            else
                send_item(directed_text[i][7:0], 1'b0);
        end
        while (items_sent < RANDOM_ITEMS)
            send_fragment();
        send_text_end();
        text_in_ch.valid <= 1'b0;

        do @(posedge clk); while (results_due != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb_c_comment_stripper_top: done, clean");
        else
            $display("tb_c_comment_stripper_top: done, errors");
        $finish;
    end

    initial
    begin : drain
        int stall;
        text_out_ch.ready = 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever
        begin
            stall = draw_wait(SIDE_OUT);
            if (stall > 0)
            begin
                text_out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            text_out_ch.ready <= 1'b1;
            do @(posedge clk); while (!text_out_ch.valid);
        end
    end

    // End the run when neither channel has moved an item for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((text_in_ch.valid && text_in_ch.ready) ||
                (text_out_ch.valid && text_out_ch.ready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= IDLE_LIMIT)
            begin
                $display("tb_c_comment_stripper_top: done, errors");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

`default_nettype wire
